// ----- rtl/core/kdht_pkg.sv -----
package kdht_pkg;

   localparam int NUM_KEYS       = 3;
   localparam int RAW_WIDTH      = 3;
   localparam int HOLD_WIDTH     = 16;
   localparam int PERIOD_WIDTH   = 10;
   localparam int COUNT_WIDTH    = 3;
   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [HOLD_WIDTH-1:0]   HOLD_CAP       = 16'd65000;
   localparam logic [COUNT_WIDTH-1:0]  DEBOUNCE_LIMIT = 3'd3;

   localparam logic [HOLD_WIDTH-1:0]   PRESS_TIME_RST     = 16'd50;
   localparam logic [PERIOD_WIDTH-1:0] SCAN_PERIOD_RST    = 10'd10;
   localparam logic [HOLD_WIDTH-1:0]   RELEASE_MARKER_RST = 16'hFFFF;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_PRESS_TIME     = 2'd0,
      CSR_SCAN_PERIOD    = 2'd1,
      CSR_RELEASE_MARKER = 2'd2
   } csr_idx_type;

   typedef struct packed {
      logic [HOLD_WIDTH-1:0]   press_time;
      logic [PERIOD_WIDTH-1:0] scan_period;
      logic [HOLD_WIDTH-1:0]   release_marker;
   } cfg_type;

   // per-key scan command from the input stage
   typedef struct packed {
      logic step;
      logic clear;
   } scan_ctl_type;

endpackage

// ----- rtl/core/kdht_csr.sv -----
module kdht_csr (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [kdht_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [kdht_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output kdht_pkg::cfg_type                     cfg
);

   kdht_pkg::cfg_type cfg_ff;
   kdht_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            kdht_pkg::CSR_PRESS_TIME:
               cfg_in.press_time = csr_wdata;
            kdht_pkg::CSR_SCAN_PERIOD:
               cfg_in.scan_period = csr_wdata[kdht_pkg::PERIOD_WIDTH-1:0];
            kdht_pkg::CSR_RELEASE_MARKER:
               cfg_in.release_marker = csr_wdata;
            default: ;   // unknown index is dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_time     <= kdht_pkg::PRESS_TIME_RST;
         cfg_ff.scan_period    <= kdht_pkg::SCAN_PERIOD_RST;
         cfg_ff.release_marker <= kdht_pkg::RELEASE_MARKER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- rtl/core/kdht_key_cell.sv -----
module kdht_key_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  kdht_pkg::scan_ctl_type              ctl,
   input  logic                                pressed_raw,
   input  kdht_pkg::cfg_type                   cfg,
   output logic [kdht_pkg::HOLD_WIDTH-1:0]     hold,
   output logic                                pressed
);

   logic                                 state_ff, state_in;
   logic                                 seen_ff, seen_in;
   logic [kdht_pkg::COUNT_WIDTH-1:0]     cnt_ff, cnt_in;
   logic [kdht_pkg::HOLD_WIDTH-1:0]      hold_ff, hold_in;

   logic [kdht_pkg::COUNT_WIDTH-1:0]     cnt_base;
   logic [kdht_pkg::COUNT_WIDTH-1:0]     cnt_inc;
   logic                                 over;
   logic [kdht_pkg::HOLD_WIDTH:0]        sum;

   assign hold    = hold_ff;
   assign pressed = state_ff;

   always_comb begin
      state_in = state_ff;
      seen_in  = seen_ff;
      hold_in  = hold_ff;
      cnt_base = cnt_ff;
      // first disagreement ever restarts the count
      if ((state_ff != pressed_raw) && !seen_ff) begin
         cnt_base = '0;
         seen_in  = 1'b1;
      end
      cnt_inc = cnt_base + kdht_pkg::COUNT_WIDTH'(1);
      over    = cnt_inc > kdht_pkg::DEBOUNCE_LIMIT;
      sum     = {1'b0, hold_ff} + (kdht_pkg::HOLD_WIDTH+1)'(cfg.scan_period);
      cnt_in  = cnt_inc;

      if (!state_ff) begin
         if (pressed_raw) begin
            if (over) begin
               hold_in  = cfg.press_time;
               cnt_in   = '0;
               state_in = 1'b1;
               seen_in  = 1'b1;
            end
         end else begin
            cnt_in  = '0;
            hold_in = '0;
         end
      end else begin
         if (pressed_raw) begin
            if (over) begin
               cnt_in = '0;
            end
            if (sum >= {1'b0, kdht_pkg::HOLD_CAP}) begin
               hold_in = kdht_pkg::HOLD_CAP;
            end else begin
               hold_in = sum[kdht_pkg::HOLD_WIDTH-1:0];
            end
         end else if (over) begin
            hold_in  = cfg.release_marker;
            cnt_in   = '0;
            state_in = 1'b0;
            seen_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (ctl.step && ctl.clear)) begin
         state_ff <= 1'b0;
         seen_ff  <= 1'b0;
         cnt_ff   <= '0;
         hold_ff  <= '0;
      end else if (ctl.step) begin
         state_ff <= state_in;
         seen_ff  <= seen_in;
         cnt_ff   <= cnt_in;
         hold_ff  <= hold_in;
      end
   end

   // count never rests above the debounce limit
   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= kdht_pkg::DEBOUNCE_LIMIT)
      else $error("scan count above limit");

   // a key cannot be debounced-pressed before it has seen a change
   a_press_needs_seen: assert property (@(posedge clock) disable iff (reset)
      state_ff |-> seen_ff)
      else $error("pressed without seen_change");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      ctl.step && ctl.clear |=> (hold_ff == '0) && !state_ff && !seen_ff)
      else $error("clear left key state behind");

endmodule

// ----- rtl/core/key_debounce_hold_timer.sv -----
// Key debounce and hold timer.
// req channel: one item per scan tick (raw_keys active low, clear_all).
// rsp channel: one item per request, carrying hold times and debounced
// pressed flags after that scan. csr channel: register writes (index 0
// press time, 1 scan period, 2 release marker); csr_ready is always high,
// unknown indexes are ignored. Write registers only while idle.
// Throughput: one item per cycle while rsp_stall does not hold a waiting
// result. An item sits in the input register, then the per-key update
// writes the key state registers, which double as the result register;
// every key is updated side by side.
// Stall: while a result waits under rsp_stall, one more item is taken into
// the input register; req_stall rises only when that register is also full.
// Reset clears all key state, the handshakes and loads the register
// defaults (50, 10, 65535). No result is emitted for reset.
module key_debounce_hold_timer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [kdht_pkg::RAW_WIDTH-1:0]       req_raw_keys,
   input  logic                                 req_clear_all,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [kdht_pkg::HOLD_WIDTH-1:0]      rsp_hold_main,
   output logic [kdht_pkg::HOLD_WIDTH-1:0]      rsp_hold_plus,
   output logic [kdht_pkg::HOLD_WIDTH-1:0]      rsp_hold_minus,
   output logic [kdht_pkg::RAW_WIDTH-1:0]       rsp_pressed_keys,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [kdht_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [kdht_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   kdht_pkg::cfg_type                    cfg;
   logic                                 s1_valid_ff, s1_valid_in;
   logic [kdht_pkg::RAW_WIDTH-1:0]       s1_raw_ff;
   logic                                 s1_clear_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic                                 out_blocked;
   logic                                 advance;
   logic                                 req_take;
   kdht_pkg::scan_ctl_type               ctl;
   logic [kdht_pkg::HOLD_WIDTH-1:0]      key_hold [kdht_pkg::NUM_KEYS];
   logic [kdht_pkg::NUM_KEYS-1:0]        key_pressed;
   logic [kdht_pkg::HOLD_WIDTH-1:0]      rep_hold [kdht_pkg::RAW_WIDTH];
   logic [kdht_pkg::RAW_WIDTH-1:0]       rep_pressed;

   kdht_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign out_blocked = rsp_valid_ff && rsp_stall;
   assign advance     = s1_valid_ff && !out_blocked;
   assign req_stall   = s1_valid_ff && out_blocked;
   assign req_take    = req_valid && !req_stall;

   assign ctl.step  = advance;
   assign ctl.clear = s1_clear_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (req_take) begin
         s1_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_raw_ff   <= req_raw_keys;
         s1_clear_ff <= req_clear_all;
      end
   end

   for (genvar k = 0; k < kdht_pkg::NUM_KEYS; k++) begin : g_key
      logic pressed_raw;
      if (k < kdht_pkg::RAW_WIDTH) begin : g_pin
         assign pressed_raw = ~s1_raw_ff[k];
      end else begin : g_nopin
         assign pressed_raw = 1'b1;   // no pin: reads as pressed
      end
      kdht_key_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .pressed_raw (pressed_raw),
         .cfg         (cfg),
         .hold        (key_hold[k]),
         .pressed     (key_pressed[k])
      );
   end

   for (genvar k = 0; k < kdht_pkg::RAW_WIDTH; k++) begin : g_rep
      if (k < kdht_pkg::NUM_KEYS) begin : g_used
         assign rep_hold[k]    = key_hold[k];
         assign rep_pressed[k] = key_pressed[k];
      end else begin : g_unused
         assign rep_hold[k]    = '0;
         assign rep_pressed[k] = 1'b0;
      end
   end

   // key state registers only change on advance, so they hold the result
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hold_main    = rep_hold[0];
   assign rsp_hold_plus    = rep_hold[1];
   assign rsp_hold_minus   = rep_hold[2];
   assign rsp_pressed_keys = rep_pressed;

   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff))
      else $error("result without a pending item");

endmodule
